### hdl/cxpc_pkg.sv
// Package for the chained XOR packet codec.
// Holds opcodes, register indexes, header constants and the result type.
// No dependencies.
package cxpc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DRAIN  = 2'd1,
    OP_START  = 2'd2,
    OP_DECODE = 2'd3
  } op_e;

  localparam logic [1:0] CFG_FIXED_KEY  = 2'd0;
  localparam logic [1:0] CFG_RANDOM_KEY = 2'd1;
  localparam logic [1:0] CFG_ENCRYPT_EN = 2'd2;

  localparam logic [7:0] FIXED_KEY_RST  = 8'h32;
  localparam logic [7:0] RANDOM_KEY_RST = 8'h31;
  localparam logic       ENCRYPT_RST    = 1'b1;

  localparam logic [7:0] CODE_ENCRYPTED = 8'h77;
  localparam logic [7:0] CODE_PLAIN     = 8'hbb;
  localparam int unsigned HEADER_LEN    = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       check_ok;
    logic       error;
  } result_t;

endpackage

### hdl/chained_xor_packet_codec_top.sv
// A result reaches the output register in the cycle after its request is
// accepted; a drained payload byte passes the buffer's read register first.
// One request per cycle while in_stall_o is low; a buffer read holds it high.
// Reset is asynchronous and active low; it clears counters and chains and
// returns the key and mode registers to their defaults.
// The payload buffer is not cleared and holds old data until reloaded.
module chained_xor_packet_codec_top #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] header_key_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic       check_ok_o,
  output logic       error_flag_o
);
  import cxpc_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          out_free;
  logic          res_valid;
  result_t       res;
  result_t       res_out;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  assign cfg_ready_o = 1'b1;

  cxpc_ram #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cxpc_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .data_byte_i  (data_byte_i),
    .header_key_i (header_key_i),
    .last_byte_i  (last_byte_i),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata)
  );

  cxpc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .free_o      (out_free)
  );

  assign out_byte_o   = res_out.data;
  assign frame_end_o  = res_out.frame_end;
  assign check_ok_o   = res_out.check_ok;
  assign error_flag_o = res_out.error;

endmodule

### hdl/cxpc_ram.sv
// Payload buffer of the packet codec: one write port, one read port.
// Synchronous read, registered while re_i is high. No dependencies.
module cxpc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hdl/cxpc_obuf.sv
// Output register of the packet codec between the core and the result channel.
// Depends on cxpc_pkg for the result type.
module cxpc_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  cxpc_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output cxpc_pkg::result_t res_o,
  output logic              free_o
);
  import cxpc_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

### hdl/cxpc_ctrl.sv
// Control core of the packet codec: configuration, load, drain and decode.
// Reads and writes the payload buffer; depends on cxpc_pkg.
module cxpc_ctrl #(
  parameter int unsigned MAX_PAYLOAD = 1024,
  parameter int unsigned AW          = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        header_key_i,
  input  logic              last_byte_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output cxpc_pkg::result_t res_o,
  output logic              we_o,
  output logic [AW-1:0]     waddr_o,
  output logic [7:0]        wdata_o,
  output logic              re_o,
  output logic [AW-1:0]     raddr_o,
  input  logic [7:0]        rdata_i
);
  import cxpc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + HEADER_LEN);
  localparam int unsigned CMP_W = POS_W + 1;

  typedef enum logic {ST_IDLE, ST_READ} state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] dpos_q, dpos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       inner_q, inner_d;
  logic [7:0]       outer_q, outer_d;
  logic [7:0]       dkey_q, dkey_d;
  logic [7:0]       exp_q, exp_d;
  logic [7:0]       decpos_q, decpos_d;
  logic [7:0]       fkey_q, fkey_d;
  logic [7:0]       rkey_q, rkey_d;
  logic             enc_q, enc_d;

  logic             accept;
  op_e              op;
  logic             load_ok;
  logic             drain_end;
  logic [15:0]      len16;
  logic [7:0]       enc_pos;
  logic [7:0]       raw;
  logic [7:0]       enc_p;
  logic [7:0]       enc_e;
  logic [7:0]       dec_pos;
  logic [7:0]       dec_p;
  logic [7:0]       dec_d;
  logic [7:0]       dec_exp;
  logic [7:0]       st_c1;
  logic             finish;
  logic [7:0]       fin_byte;

  assign in_stall_o = (state_q != ST_IDLE) || !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = op_e'(opcode_i);
  assign load_ok    = (cnt_q < CNT_W'(MAX_PAYLOAD)) && (dpos_q == '0);
  assign drain_end  = CMP_W'(dpos_q) >= (CMP_W'(cnt_q) + CMP_W'(HEADER_LEN - 1));
  assign len16      = 16'(cnt_q);

  assign enc_pos = 8'(dpos_q) - 8'd3;
  assign raw     = (state_q == ST_READ) ? rdata_i : sum_q;
  assign enc_p   = raw ^ (inner_q + rkey_q + enc_pos);
  assign enc_e   = enc_p ^ (outer_q + fkey_q + enc_pos);

  assign dec_pos = decpos_q + 8'd2;
  assign dec_p   = data_byte_i ^ (outer_q + fkey_q + dec_pos);
  assign dec_d   = dec_p ^ (inner_q + dkey_q + dec_pos);
  assign dec_exp = exp_q - dec_d;
  assign st_c1   = data_byte_i ^ (fkey_q + 8'd1);

  assign we_o    = accept && (op == OP_LOAD) && load_ok;
  assign waddr_o = AW'(cnt_q);
  assign wdata_o = data_byte_i;
  assign raddr_o = AW'(dpos_q - POS_W'(HEADER_LEN));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dpos_d      = dpos_q;
    sum_d       = sum_q;
    inner_d     = inner_q;
    outer_d     = outer_q;
    dkey_d      = dkey_q;
    exp_d       = exp_q;
    decpos_d    = decpos_q;
    fkey_d      = fkey_q;
    rkey_d      = rkey_q;
    enc_d       = enc_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    re_o        = 1'b0;
    finish      = 1'b0;
    fin_byte    = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIXED_KEY:  fkey_d = cfg_data_i;
        CFG_RANDOM_KEY: rkey_d = cfg_data_i;
        CFG_ENCRYPT_EN: enc_d  = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              if (load_ok) begin
                cnt_d = cnt_q + CNT_W'(1);
                sum_d = sum_q + data_byte_i;
              end else begin
                res_valid_o = 1'b1;
                res_o.error = 1'b1;
              end
            end
            OP_DRAIN: begin
              if (cnt_q == '0) begin
                res_valid_o = 1'b1;
                res_o.error = 1'b1;
              end else if (dpos_q >= POS_W'(HEADER_LEN)) begin
                re_o    = 1'b1;
                state_d = ST_READ;
              end else begin
                finish = 1'b1;
                case (dpos_q)
                  POS_W'(0): begin
                    inner_d  = '0;
                    outer_d  = '0;
                    fin_byte = enc_q ? CODE_ENCRYPTED : CODE_PLAIN;
                  end
                  POS_W'(1): fin_byte = len16[7:0];
                  POS_W'(2): fin_byte = len16[15:8];
                  POS_W'(3): fin_byte = rkey_q;
                  default: begin
                    if (enc_q) begin
                      fin_byte = enc_e;
                      inner_d  = enc_p;
                      outer_d  = enc_e;
                    end else begin
                      fin_byte = raw;
                    end
                  end
                endcase
              end
            end
            OP_START: begin
              dkey_d   = header_key_i;
              outer_d  = data_byte_i;
              inner_d  = st_c1;
              exp_d    = st_c1 ^ (header_key_i + 8'd1);
              decpos_d = '0;
            end
            default: begin
              outer_d         = data_byte_i;
              inner_d         = dec_p;
              exp_d           = dec_exp;
              decpos_d        = decpos_q + 8'd1;
              res_valid_o     = 1'b1;
              res_o.data      = dec_d;
              res_o.frame_end = last_byte_i;
              res_o.check_ok  = last_byte_i && (dec_exp == '0);
            end
          endcase
        end
      end
      default: begin
        finish  = 1'b1;
        state_d = ST_IDLE;
        if (enc_q) begin
          fin_byte = enc_e;
          inner_d  = enc_p;
          outer_d  = enc_e;
        end else begin
          fin_byte = raw;
        end
      end
    endcase

    if (finish) begin
      res_valid_o     = 1'b1;
      res_o.data      = fin_byte;
      res_o.frame_end = drain_end;
      if (drain_end) begin
        cnt_d  = '0;
        dpos_d = '0;
        sum_d  = '0;
      end else begin
        dpos_d = dpos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      dpos_q   <= '0;
      sum_q    <= '0;
      inner_q  <= '0;
      outer_q  <= '0;
      dkey_q   <= '0;
      exp_q    <= '0;
      decpos_q <= '0;
      fkey_q   <= FIXED_KEY_RST;
      rkey_q   <= RANDOM_KEY_RST;
      enc_q    <= ENCRYPT_RST;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      dpos_q   <= dpos_d;
      sum_q    <= sum_d;
      inner_q  <= inner_d;
      outer_q  <= outer_d;
      dkey_q   <= dkey_d;
      exp_q    <= exp_d;
      decpos_q <= decpos_d;
      fkey_q   <= fkey_d;
      rkey_q   <= rkey_d;
      enc_q    <= enc_d;
    end
  end

endmodule

### hdl/cxpc_checker.sv
// Port-level checks for the chained XOR packet codec and their bind.
// Watches only the top level's result channel; no package dependency.
module cxpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [7:0] out_byte_i,
  input logic       frame_end_i,
  input logic       check_ok_i,
  input logic       error_flag_i
);

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_flag_i |-> out_byte_i == 8'd0 && !frame_end_i && !check_ok_i)
    else $error("error result carries nonzero fields");

  a_ok_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && check_ok_i |-> frame_end_i)
    else $error("check_ok raised outside a frame end");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("stalled result dropped");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_byte_i) && $stable(frame_end_i))
    else $error("stalled result changed");

endmodule

bind chained_xor_packet_codec_top cxpc_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_i   (out_byte_o),
  .frame_end_i  (frame_end_o),
  .check_ok_i   (check_ok_o),
  .error_flag_i (error_flag_o)
);
